FILE: rtl/core/psm_pkg.sv
// shared constants, types and the quarter-wave sine table for the psk sine modulator
package psm_pkg;

   localparam int SINE_ADDR_BITS = 10;
   localparam int SAMPLE_BITS    = 16;
   localparam int MAG_BITS       = SAMPLE_BITS - 1;
   localparam int QUARTER_BITS   = SINE_ADDR_BITS - 2;
   localparam int ROM_DEPTH      = 1 << QUARTER_BITS;
   localparam int ROM_IDX_BITS   = QUARTER_BITS + 1;

   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 32;
   localparam int SPB_BITS       = 7;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_PHASE_STEP      = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SAMPLES_PER_BIT = 1'd1;

   localparam logic [CSR_DATA_BITS-1:0] PHASE_STEP_RESET = 32'd268435456;
   localparam logic [SPB_BITS-1:0]      SPB_RESET        = 7'd16;

   localparam longint Q30_ONE  = 64'sd1 <<< 30;
   localparam longint Q30_HALF = 64'sd1 <<< 29;
   localparam longint FULL_SCALE = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;

   typedef logic [MAG_BITS-1:0] sine_rom_type [ROM_DEPTH];

   typedef struct packed {
      logic [SINE_ADDR_BITS-1:0] addr;
      logic                      last;
   } sine_req_type;

   function automatic longint q30_mul(longint a, longint b);
      return (a * b + Q30_HALF) >>> 30;
   endfunction

   function automatic longint sine_coef(int i);
      longint c;
      case (i)
         0:       c = 64'sd1686629713;
         1:       c = -64'sd693598668;
         2:       c = 64'sd85569306;
         3:       c = -64'sd5026995;
         4:       c = 64'sd172272;
         5:       c = -64'sd3864;
         default: c = 64'sd61;
      endcase
      return c;
   endfunction

   // sin(pi/2 * u), u and result in q30
   function automatic longint quarter_sine(longint u);
      longint u2;
      longint acc;
      u2  = q30_mul(u, u);
      acc = sine_coef(6);
      for (int i = 5; i >= 0; i--) begin
         acc = sine_coef(i) + q30_mul(acc, u2);
      end
      acc = q30_mul(acc, u);
      if (acc < 0) acc = 0;
      if (acc > Q30_ONE) acc = Q30_ONE;
      return acc;
   endfunction

   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      longint u;
      longint s;
      longint mag;
      for (int i = 0; i < ROM_DEPTH; i++) begin
         u      = longint'(i) <<< (32 - SINE_ADDR_BITS);
         s      = quarter_sine(u);
         mag    = (s * FULL_SCALE + Q30_HALF) >>> 30;
         rom[i] = MAG_BITS'(mag);
      end
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine_rom();

endpackage

FILE: rtl/core/psk_sine_modulator_core.sv
// psk sine modulator top level: control registers, sequencer and sine output stage
//
//  channel   signals                                   direction
//  req       req_valid/ready, data_bit, frame_start    in
//  rsp       rsp_valid/ready, sample, last_of_bit      out
//  csr       csr_wr_en, csr_index, csr_wdata           in, write only
//
// one sample per clock when rsp_ready stays high; a bit takes samples_per_bit
// samples (1 to MAX_SAMPLES_PER_BIT), set by the sample counter in the sequencer.
// a bit's first sample passes the sequencer state, the sine request register and
// the output register; the sequencer takes the next bit as it issues the last sample.
// synchronous reset clears the phase accumulator and loads the register defaults.
// an rsp_ready stall holds full registers; the sequencer stalls once both are full.
module psk_sine_modulator_core #(
   parameter int PHASE_BITS          = 32,
   parameter int MAX_SAMPLES_PER_BIT = 64
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_data_bit,
   input  logic                                   req_frame_start,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [psm_pkg::SAMPLE_BITS-1:0] rsp_sample,
   output logic                                   rsp_last_of_bit,
   input  logic                                   csr_wr_en,
   input  logic [psm_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [psm_pkg::CSR_DATA_BITS-1:0]      csr_wdata
);
   import psm_pkg::*;

   logic [CSR_DATA_BITS-1:0] phase_step_ff, phase_step_in;
   logic [SPB_BITS-1:0]      spb_ff, spb_in;

   logic         sine_valid;
   logic         sine_ready;
   sine_req_type sine_req;

   always_comb begin
      phase_step_in = phase_step_ff;
      spb_in        = spb_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_PHASE_STEP:      phase_step_in = csr_wdata;
            CSR_SAMPLES_PER_BIT: spb_in        = csr_wdata[SPB_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff <= PHASE_STEP_RESET;
         spb_ff        <= SPB_RESET;
      end else begin
         phase_step_ff <= phase_step_in;
         spb_ff        <= spb_in;
      end
   end

   psm_sequencer #(
      .PHASE_BITS          (PHASE_BITS),
      .MAX_SAMPLES_PER_BIT (MAX_SAMPLES_PER_BIT)
   ) u_sequencer (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_bit    (req_data_bit),
      .req_frame_start (req_frame_start),
      .phase_step      (phase_step_ff),
      .samples_per_bit (spb_ff),
      .sine_valid      (sine_valid),
      .sine_req        (sine_req),
      .sine_ready      (sine_ready)
   );

   psm_sine_lookup u_sine_lookup (
      .clock           (clock),
      .reset           (reset),
      .sine_valid      (sine_valid),
      .sine_req        (sine_req),
      .sine_ready      (sine_ready),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_sample      (rsp_sample),
      .rsp_last_of_bit (rsp_last_of_bit)
   );

endmodule

FILE: rtl/core/psm_sequencer.sv
// per-bit sample sequencer: holds the current bit, phase accumulator and sample count
module psm_sequencer #(
   parameter int PHASE_BITS          = 32,
   parameter int MAX_SAMPLES_PER_BIT = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_data_bit,
   input  logic                               req_frame_start,
   input  logic [psm_pkg::CSR_DATA_BITS-1:0]  phase_step,
   input  logic [psm_pkg::SPB_BITS-1:0]       samples_per_bit,
   output logic                               sine_valid,
   output psm_pkg::sine_req_type              sine_req,
   input  logic                               sine_ready
);
   import psm_pkg::*;

   localparam int IDX_W = (MAX_SAMPLES_PER_BIT > 1) ? $clog2(MAX_SAMPLES_PER_BIT) : 1;
   localparam logic [SPB_BITS-1:0] MAX_SPB = SPB_BITS'(MAX_SAMPLES_PER_BIT);
   localparam logic [PHASE_BITS-1:0] OFFSET_ONE  = PHASE_BITS'(1) << (PHASE_BITS - 2);
   localparam logic [PHASE_BITS-1:0] OFFSET_ZERO = '0 - (PHASE_BITS'(1) << (PHASE_BITS - 3));

   logic                  busy_ff, busy_in;
   logic                  bit_ff, bit_in;
   logic [IDX_W-1:0]      count_ff, count_in;
   logic [IDX_W-1:0]      last_idx_ff, last_idx_in;
   logic [PHASE_BITS-1:0] carrier_ff, carrier_in;
   logic                  sine_valid_ff, sine_valid_in;
   sine_req_type          sine_req_ff, sine_req_in;

   logic                  emit;
   logic                  is_last;
   logic                  accept;
   logic [SPB_BITS-1:0]   spb_eff;
   logic [PHASE_BITS-1:0] phase_sum;
   logic [PHASE_BITS-1:0] carrier_adv;

   always_comb begin
      if (samples_per_bit == '0) begin
         spb_eff = SPB_BITS'(1);
      end else if (samples_per_bit > MAX_SPB) begin
         spb_eff = MAX_SPB;
      end else begin
         spb_eff = samples_per_bit;
      end
   end

   assign emit        = busy_ff && (!sine_valid_ff || sine_ready);
   assign is_last     = (count_ff == last_idx_ff);
   assign req_ready   = !busy_ff || (emit && is_last);
   assign accept      = req_valid && req_ready;
   assign phase_sum   = carrier_ff + (bit_ff ? OFFSET_ONE : OFFSET_ZERO);
   assign carrier_adv = emit ? carrier_ff + PHASE_BITS'(phase_step) : carrier_ff;

   always_comb begin
      busy_in       = busy_ff;
      bit_in        = bit_ff;
      count_in      = count_ff;
      last_idx_in   = last_idx_ff;
      carrier_in    = carrier_adv;
      sine_valid_in = sine_valid_ff;
      sine_req_in   = sine_req_ff;
      if (sine_ready) begin
         sine_valid_in = 1'b0;
      end
      if (emit) begin
         sine_valid_in    = 1'b1;
         sine_req_in.addr = phase_sum[PHASE_BITS-1 -: SINE_ADDR_BITS];
         sine_req_in.last = is_last;
         count_in         = count_ff + IDX_W'(1);
         if (is_last) begin
            busy_in = 1'b0;
         end
      end
      if (accept) begin
         busy_in     = 1'b1;
         bit_in      = req_data_bit;
         count_in    = '0;
         last_idx_in = IDX_W'(spb_eff - SPB_BITS'(1));
         if (req_frame_start) begin
            carrier_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         sine_valid_ff <= 1'b0;
         carrier_ff    <= '0;
      end else begin
         busy_ff       <= busy_in;
         sine_valid_ff <= sine_valid_in;
         carrier_ff    <= carrier_in;
      end
   end

   always_ff @(posedge clock) begin
      bit_ff      <= bit_in;
      count_ff    <= count_in;
      last_idx_ff <= last_idx_in;
      sine_req_ff <= sine_req_in;
   end

   assign sine_valid = sine_valid_ff;
   assign sine_req   = sine_req_ff;

endmodule

FILE: rtl/core/psm_sine_lookup.sv
// quarter-wave sine table lookup with sign and the output register
module psm_sine_lookup (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                sine_valid,
   input  psm_pkg::sine_req_type               sine_req,
   output logic                                sine_ready,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [psm_pkg::SAMPLE_BITS-1:0] rsp_sample,
   output logic                                rsp_last_of_bit
);
   import psm_pkg::*;

   localparam logic [ROM_IDX_BITS-1:0] ROM_TOP = ROM_IDX_BITS'(ROM_DEPTH);

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic                   last_ff, last_in;

   logic [1:0]              quad;
   logic [QUARTER_BITS-1:0] quarter_pos;
   logic [ROM_IDX_BITS-1:0] rom_idx;
   logic [MAG_BITS-1:0]     mag;
   logic [SAMPLE_BITS-1:0]  mag_ext;

   assign quad        = sine_req.addr[SINE_ADDR_BITS-1 -: 2];
   assign quarter_pos = sine_req.addr[QUARTER_BITS-1:0];
   assign rom_idx     = quad[0] ? ROM_TOP - ROM_IDX_BITS'(quarter_pos)
                                : ROM_IDX_BITS'(quarter_pos);
   // peak of the quarter wave
   assign mag         = rom_idx[QUARTER_BITS] ? MAG_BITS'(FULL_SCALE)
                                              : SINE_ROM[rom_idx[QUARTER_BITS-1:0]];
   assign mag_ext     = SAMPLE_BITS'(mag);

   assign sine_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      sample_in    = sample_ff;
      last_in      = last_ff;
      if (sine_ready) begin
         rsp_valid_in = sine_valid;
         if (sine_valid) begin
            sample_in = quad[1] ? '0 - mag_ext : mag_ext;
            last_in   = sine_req.last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      last_ff   <= last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_sample      = signed'(sample_ff);
   assign rsp_last_of_bit = last_ff;

endmodule
